// ===== sv/bxds_pkg.sv =====
package bxds_pkg;

    // Field widths of the pixel stream and the configuration registers.
    localparam int PIXEL_W   = 8;
    localparam int SCALE_W   = 7;
    localparam int DIM_W     = 13;
    localparam int ROW_W     = 12;
    localparam int CFG_IDX_W = 2;

    // Accumulator widths; sums wrap at these widths.
    localparam int RUNSUM_W = 14;
    localparam int COLSUM_W = 20;

    // Frame height saturates here, and width and height reset to it.
    localparam int HEIGHT_LIMIT = 4096;
    localparam int DIM_RESET    = 4096;

    // Reciprocal multiply: q = (x * ceil(2^27 / d)) >> 27 is exact for x < 2^20, d < 128.
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP_W     = 28;
    localparam int RECIP_DEPTH = 128;
    localparam int PROD_W      = COLSUM_W + RECIP_W;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SCALE  = 2'd0;
    localparam t_cfg_idx CFG_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_HEIGHT = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IN,
        ST_ADDR,
        ST_SUM,
        ST_DIV1,
        ST_DIV2,
        ST_OUT
    } t_state;

    typedef logic [RECIP_W-1:0] t_recip_tab [RECIP_DEPTH];

    // Builds the reciprocal table by long division; evaluated at elaboration only.
    function automatic t_recip_tab build_recip_tab();
        t_recip_tab                        tab;
        logic [RECIP_SHIFT+SCALE_W-1:0]    num;
        logic [RECIP_SHIFT+SCALE_W-1:0]    quo;
        logic [SCALE_W:0]                  rem;
        for (int d = 0; d < RECIP_DEPTH; d++) begin
            if (d == 0) begin
                tab[d] = '0;
            end else begin
                num = (RECIP_SHIFT+SCALE_W)'(1) << RECIP_SHIFT;
                num = num + (RECIP_SHIFT+SCALE_W)'(d - 1);
                quo = '0;
                rem = '0;
                for (int i = RECIP_SHIFT + SCALE_W - 1; i >= 0; i--) begin
                    rem = {rem[SCALE_W-1:0], num[i]};
                    if (rem >= (SCALE_W+1)'(d)) begin
                        rem    = rem - (SCALE_W+1)'(d);
                        quo[i] = 1'b1;
                    end
                end
                tab[d] = quo[RECIP_W-1:0];
            end
        end
        return tab;
    endfunction

    localparam t_recip_tab RECIP_TAB = build_recip_tab();

endpackage

// ===== sv/bxds_ram.sv =====
module bxds_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bxds_div.sv =====
module bxds_div (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic [bxds_pkg::COLSUM_W-1:0]  i_dividend,
    input  logic [bxds_pkg::SCALE_W-1:0]   i_divisor,
    output logic [bxds_pkg::COLSUM_W-1:0]  o_quot
);

    import bxds_pkg::*;

    logic [RECIP_W-1:0]  recip;
    logic [PROD_W-1:0]   prod;
    logic [COLSUM_W-1:0] r_quot;

    // Division by a small divisor as a multiply by its rounded-up reciprocal.
    assign recip = RECIP_TAB[i_divisor];
    assign prod  = PROD_W'(i_dividend) * PROD_W'(recip);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quot <= prod[RECIP_SHIFT+COLSUM_W-1:RECIP_SHIFT];
        end
    end

    assign o_quot = r_quot;

endmodule

// ===== sv/box_average_downscaler_core.sv =====
// Box-average downscaler. Pixels enter in raster order on the input word channel
// (i_in_valid / o_in_ready, payload i_pixel and i_frame_start). Each complete
// scale-by-scale block yields one word on the output channel (o_out_valid /
// i_out_ready) carrying the truncated block mean plus row-end and frame-end marks.
// Partial blocks at the right and bottom edges produce nothing.
// Configuration words (scale, image_width, image_height by index 0..2) are taken
// at any cycle on the i_cfg_valid / o_cfg_ready channel and must only be sent
// while no pixel is in flight.
// Sequencing: a pixel that does not close a block column inside the image width is
// handled in ST_IN alone. A pixel that closes one goes on through ST_ADDR and ST_SUM
// (column-sum read-modify-write in the line memory). A pixel that completes a block
// also passes ST_DIV1, ST_DIV2 and ST_OUT: the read-modify-write plus two passes
// through the shared reciprocal multiplier; its output word is loaded in ST_OUT.
// Reset: after i_rst_n is released the line memory is cleared one entry per cycle,
// all MAX_WIDTH entries, during which no pixel is accepted.
// When the receiver stalls, further pixels are still accepted until one needs to
// place a new output word while the previous one is still waiting.
module box_average_downscaler_core #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_SCALE = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [bxds_pkg::PIXEL_W-1:0]    i_pixel,
    input  logic                            i_frame_start,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [bxds_pkg::PIXEL_W-1:0]    o_out_pixel,
    output logic                            o_row_end,
    output logic                            o_frame_end,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bxds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bxds_pkg::DIM_W-1:0]      i_cfg_data
);

    import bxds_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = CW + 1;
    localparam int WB_W  = $clog2(MAX_SCALE);
    localparam int CMP_W = ((CW > DIM_W) ? CW : DIM_W) + 2;
    localparam int W_RST = (MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET;

    localparam logic [CMP_W-1:0]   ONE_C     = CMP_W'(1);
    localparam logic [CMP_W-1:0]   MAXW_C    = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0]   HLIM_C    = CMP_W'(HEIGHT_LIMIT);
    localparam logic [SCALE_W+1:0] MAXS_C    = (SCALE_W+2)'(MAX_SCALE);
    localparam logic [CW-1:0]      LAST_ADDR = CW'(MAX_WIDTH - 1);

    // Control and configuration registers.
    t_state                  r_state, n_state;
    logic [SCALE_W-1:0]      r_scale;
    logic [WW-1:0]           r_width;
    logic [DIM_W-1:0]        r_height;
    logic [CW-1:0]           r_col;
    logic [ROW_W-1:0]        r_row;
    logic [WB_W-1:0]         r_wbc;
    logic [WB_W-1:0]         r_wbr;
    logic [RUNSUM_W-1:0]     r_run;
    logic [CW-1:0]           r_clr;
    logic                    r_first;
    logic                    r_emit;
    logic                    r_re;
    logic                    r_fe;
    logic [CW-1:0]           r_bi;
    logic [COLSUM_W-1:0]     r_sum;
    logic                    r_out_valid;
    logic [PIXEL_W-1:0]      r_out_pixel;
    logic                    r_out_row_end;
    logic                    r_out_frame_end;

    // Sequencer outputs.
    logic                    in_acc;
    logic                    div_load;
    logic [COLSUM_W-1:0]     div_dividend;
    logic [COLSUM_W-1:0]     div_quot;
    logic                    ram_we;
    logic [CW-1:0]           ram_waddr;
    logic [COLSUM_W-1:0]     ram_wdata;
    logic [COLSUM_W-1:0]     ram_rdata;
    logic                    out_free;
    logic                    out_load;

    // Per-pixel position logic.
    logic [CW-1:0]           c_col;
    logic [ROW_W-1:0]        c_row;
    logic [WB_W-1:0]         c_wbc;
    logic [WB_W-1:0]         c_wbr;
    logic [RUNSUM_W-1:0]     c_run;
    logic [CMP_W-1:0]        s_c;
    logic [CMP_W-1:0]        w_c;
    logic [CMP_W-1:0]        h_c;
    logic [CMP_W-1:0]        col_c;
    logic [CMP_W-1:0]        row_c;
    logic [CMP_W-1:0]        wbc_c;
    logic [CMP_W-1:0]        wbr_c;
    logic [CMP_W-1:0]        cstart;
    logic [CMP_W-1:0]        rstart;
    logic                    last_col;
    logic                    last_row;
    logic                    col_fits;
    logic                    row_fits;
    logic                    do_mem;
    logic                    row_wrap;
    logic                    frame_wrap;
    logic                    c_re;
    logic                    c_fe;
    logic [COLSUM_W-1:0]     c_sum;

    // Configuration write decode, stored as effective values.
    logic [SCALE_W-1:0]      cfg_scale;
    logic [WW-1:0]           cfg_width;
    logic [DIM_W-1:0]        cfg_height;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data[SCALE_W-1:0] == '0) begin
            cfg_scale = SCALE_W'(1);
        end else if ((SCALE_W+2)'(i_cfg_data[SCALE_W-1:0]) > MAXS_C) begin
            cfg_scale = SCALE_W'(MAX_SCALE);
        end else begin
            cfg_scale = i_cfg_data[SCALE_W-1:0];
        end

        if (i_cfg_data == '0) begin
            cfg_width = WW'(1);
        end else if (CMP_W'(i_cfg_data) > MAXW_C) begin
            cfg_width = WW'(MAX_WIDTH);
        end else begin
            cfg_width = WW'(i_cfg_data);
        end

        if (i_cfg_data == '0) begin
            cfg_height = DIM_W'(1);
        end else if (CMP_W'(i_cfg_data) > HLIM_C) begin
            cfg_height = DIM_W'(HEIGHT_LIMIT);
        end else begin
            cfg_height = i_cfg_data;
        end
    end

    // Position of the incoming pixel, after a frame start clears the counters.
    always_comb begin
        c_col = i_frame_start ? '0 : r_col;
        c_row = i_frame_start ? '0 : r_row;
        c_wbc = i_frame_start ? '0 : r_wbc;
        c_wbr = i_frame_start ? '0 : r_wbr;
        c_run = (c_wbc == '0) ? RUNSUM_W'(i_pixel) : r_run + RUNSUM_W'(i_pixel);

        s_c   = CMP_W'(r_scale);
        w_c   = CMP_W'(r_width);
        h_c   = CMP_W'(r_height);
        col_c = CMP_W'(c_col);
        row_c = CMP_W'(c_row);
        wbc_c = CMP_W'(c_wbc);
        wbr_c = CMP_W'(c_wbr);

        last_col = (wbc_c + ONE_C) >= s_c;
        last_row = (wbr_c + ONE_C) >= s_c;
        cstart   = (col_c >= wbc_c) ? col_c - wbc_c : '0;
        rstart   = (row_c >= wbr_c) ? row_c - wbr_c : '0;
        col_fits = (cstart + s_c) <= w_c;
        row_fits = (rstart + s_c) <= h_c;
        do_mem   = last_col && col_fits;

        c_re       = (col_c + ONE_C + s_c) > w_c;
        c_fe       = c_re && ((row_c + ONE_C + s_c) > h_c);
        row_wrap   = (col_c + ONE_C) >= w_c;
        frame_wrap = (row_c + ONE_C) >= h_c;
    end

    // New column sum: the first row of a block row overwrites the entry.
    assign c_sum    = (r_first ? '0 : ram_rdata) + COLSUM_W'(r_run);
    assign out_free = !r_out_valid || i_out_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and sequencer outputs.
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        in_acc       = 1'b0;
        div_load     = 1'b0;
        div_dividend = COLSUM_W'(c_col);
        ram_we       = 1'b0;
        ram_waddr    = r_bi;
        ram_wdata    = c_sum;
        out_load     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IN;
                end
            end
            ST_IN: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    in_acc   = 1'b1;
                    div_load = 1'b1;
                    if (do_mem) begin
                        n_state = ST_ADDR;
                    end
                end
            end
            ST_ADDR: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                ram_we  = 1'b1;
                n_state = r_emit ? ST_DIV1 : ST_IN;
            end
            ST_DIV1: begin
                div_load     = 1'b1;
                div_dividend = r_sum;
                n_state      = ST_DIV2;
            end
            ST_DIV2: begin
                div_load     = 1'b1;
                div_dividend = div_quot;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IN;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Configuration, position counters and clear sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_W'(1);
            r_width     <= WW'(W_RST);
            r_height    <= DIM_W'(DIM_RESET);
            r_col       <= '0;
            r_row       <= '0;
            r_wbc       <= '0;
            r_wbr       <= '0;
            r_run       <= '0;
            r_clr       <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SCALE:  r_scale  <= cfg_scale;
                    CFG_WIDTH:  r_width  <= cfg_width;
                    CFG_HEIGHT: r_height <= cfg_height;
                    default: begin
                    end
                endcase
            end

            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end

            if (in_acc) begin
                r_run  <= c_run;
                r_emit <= do_mem && last_row && row_fits;
                if (row_wrap) begin
                    r_col <= '0;
                    r_wbc <= '0;
                    if (frame_wrap) begin
                        r_row <= '0;
                        r_wbr <= '0;
                    end else begin
                        r_row <= c_row + 1'b1;
                        r_wbr <= last_row ? '0 : c_wbr + 1'b1;
                    end
                end else begin
                    r_col <= c_col + 1'b1;
                    r_wbc <= last_col ? '0 : c_wbc + 1'b1;
                    r_row <= c_row;
                    r_wbr <= c_wbr;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-block payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_first <= (c_wbr == '0);
            r_re    <= c_re;
            r_fe    <= c_fe;
        end
        if (r_state == ST_ADDR) begin
            r_bi <= div_quot[CW-1:0];
        end
        if (r_state == ST_SUM) begin
            r_sum <= c_sum;
        end
        if (out_load) begin
            r_out_pixel     <= div_quot[PIXEL_W-1:0];
            r_out_row_end   <= r_re;
            r_out_frame_end <= r_fe;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

    // Shared reciprocal divider: block index, then sum / scale twice.
    bxds_div u_div (
        .i_clk      (i_clk),
        .i_load     (div_load),
        .i_dividend (div_dividend),
        .i_divisor  (r_scale),
        .o_quot     (div_quot)
    );

    // Line memory of block-column sums.
    bxds_ram #(
        .WIDTH (COLSUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_colsum_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (div_quot[CW-1:0]),
        .o_rdata (ram_rdata)
    );

    // A frame end is always also a row end.
    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_row_end)
        else $error("frame end without row end");

    // A waiting output word is never overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) && r_out_valid && !i_out_ready |=> (r_state == ST_OUT))
        else $error("output word overwritten while stalled");

    // The column sum is written back to the entry that was read.
    a_rmw_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |-> (r_bi == $past(div_quot[CW-1:0])))
        else $error("column sum written to a different entry");

    // The clear sweep covers every entry before pixels are taken.
    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) && (r_clr != LAST_ADDR) |=>
        (r_state == ST_CLEAR) && (r_clr == $past(r_clr) + 1'b1))
        else $error("clear sweep left early");

endmodule

// ===== dv/tb_box_average_downscaler_core.sv =====
module tb_box_average_downscaler_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bxds_pkg::*;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_SCALE    = 64;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 400;
    localparam int RAND_ITEMS   = 500;
    localparam int PRINT_LIMIT  = 40;

    // No register lives at the last index; writes there must be ignored.
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PIXEL_W-1:0] pix;
        logic               fs;
    } pix_word_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] mean;
        logic               row_end;
        logic               frame_end;
    } mean_word_t;

    // Clock, reset and block ports.
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic [PIXEL_W-1:0]   i_pixel       = '0;
    logic                 i_frame_start = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic [PIXEL_W-1:0]   o_out_pixel;
    logic                 o_row_end;
    logic                 o_frame_end;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [DIM_W-1:0]     i_cfg_data    = '0;

    // Pending input words and the block means they are expected to produce.
    pix_word_t  pix_q[$];
    mean_word_t mean_q[$];

    int sent_cnt = 0;
    int acc_cnt  = 0;
    int err_cnt  = 0;

    // Idling level shared by the sender and the receiver; long-hold request for the receiver.
    int idle_level = 1;
    bit stall_go   = 1'b0;
    bit stall_done = 1'b0;

    // Shadow of the configuration registers.
    logic [SCALE_W-1:0] cfg_scale  = 7'd1;
    logic [DIM_W-1:0]   cfg_width  = DIM_W'(DIM_RESET);
    logic [DIM_W-1:0]   cfg_height = DIM_W'(DIM_RESET);

    // Shadow of the accumulation state.
    logic [COLSUM_W-1:0] col_sum_mem [MAX_WIDTH];
    logic [RUNSUM_W-1:0] row_acc = '0;
    int col_pos = 0;
    int row_pos = 0;
    int blk_col = 0;
    int blk_row = 0;

    // Process-level working variables.
    pix_word_t  drv_word;
    bit         drv_valid;
    int         gap_left   = 0;
    bit         rdy_next;
    int         hold_left  = 0;
    int         stall_left = 0;
    mean_word_t got_word;
    mean_word_t want_word;

    box_average_downscaler_core #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_pixel   (o_out_pixel),
        .o_row_end     (o_row_end),
        .o_frame_end   (o_frame_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Prints one line per mismatch, up to a limit, and counts every one.
    task automatic report_mismatch(input string what, input logic [PIXEL_W-1:0] got,
                                   input logic [PIXEL_W-1:0] want);
        if (err_cnt < PRINT_LIMIT) begin
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what,
                     got, want);
        end
        err_cnt++;
    endtask

    // Decides whether an idle burst starts this cycle, at the current idling level.
    function automatic bit idle_hit();
        case (idle_level)
            0:       return 1'b0;
            1:       return $urandom_range(0, 9) == 0;
            default: return $urandom_range(0, 2) == 0;
        endcase
    endfunction

    // Pixel values lean toward the two extremes.
    function automatic logic [PIXEL_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Advances the shadow state by one accepted pixel and queues the block mean it
    // completes, if any.
    task automatic predict_mean(input pix_word_t word);
        int s, w, h, cstart, rstart, bi;
        bit last_col, last_row;
        logic [COLSUM_W-1:0] blk_sum;
        mean_word_t res;
        s = (cfg_scale == 0) ? 1 : ((cfg_scale > MAX_SCALE) ? MAX_SCALE : int'(cfg_scale));
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
        h = (cfg_height == 0) ? 1 :
            ((cfg_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(cfg_height));

        // A frame start puts this pixel at the top left corner.
        if (word.fs) begin
            col_pos = 0;
            row_pos = 0;
            blk_col = 0;
            blk_row = 0;
            row_acc = '0;
        end

        if (blk_col == 0) begin
            row_acc = RUNSUM_W'(word.pix);
        end else begin
            row_acc = row_acc + RUNSUM_W'(word.pix);
        end

        last_col = (blk_col + 1) >= s;
        last_row = (blk_row + 1) >= s;

        // A closed block column folds its row sum into the line store; partial
        // blocks at the right edge are skipped.
        if (last_col) begin
            cstart = (col_pos >= blk_col) ? col_pos - blk_col : 0;
            rstart = (row_pos >= blk_row) ? row_pos - blk_row : 0;
            if (cstart + s <= w) begin
                bi = (col_pos / s) % MAX_WIDTH;
                blk_sum = (blk_row == 0) ? '0 : col_sum_mem[bi];
                blk_sum = blk_sum + COLSUM_W'(row_acc);
                col_sum_mem[bi] = blk_sum;
                if (last_row && (rstart + s <= h)) begin
                    res.mean      = PIXEL_W'(blk_sum / (s * s));
                    res.row_end   = (col_pos + 1 + s) > w;
                    res.frame_end = res.row_end && ((row_pos + 1 + s) > h);
                    mean_q.push_back(res);
                end
            end
        end

        // Step the raster position, wrapping at the row and frame ends.
        blk_col = last_col ? 0 : blk_col + 1;
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            blk_col = 0;
            blk_row = last_row ? 0 : blk_row + 1;
            if (row_pos + 1 >= h) begin
                row_pos = 0;
                blk_row = 0;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
    endtask

    // Sender: offers the next pending word once the previous one is taken.
    always @(negedge i_clk) begin
        if (i_rst_n && acc_cnt == sent_cnt) begin
            if (gap_left > 0) begin
                gap_left--;
                drv_valid = 1'b0;
            end else if (pix_q.size() == 0) begin
                drv_valid = 1'b0;
            end else if (idle_hit()) begin
                gap_left  = $urandom_range(0, 12);
                drv_valid = 1'b0;
            end else begin
                drv_word = pix_q.pop_front();
                i_pixel       <= drv_word.pix;
                i_frame_start <= drv_word.fs;
                sent_cnt++;
                drv_valid = 1'b1;
            end
            i_in_valid <= drv_valid;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            rdy_next = 1'b0;
        end else if (stall_go && !stall_done) begin
            stall_done = 1'b1;
            hold_left  = LONG_HOLD - 1;
            rdy_next   = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy_next = 1'b0;
        end else if (idle_hit()) begin
            stall_left = $urandom_range(0, 12);
            rdy_next   = 1'b0;
        end else begin
            rdy_next = 1'b1;
        end
        i_out_ready <= rdy_next;
    end

    // Monitor: checks each output word against the oldest expected mean, then
    // predicts from each accepted input word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got_word = '{o_out_pixel, o_row_end, o_frame_end};
                if (mean_q.size() == 0) begin
                    report_mismatch("word with none expected", got_word.mean, '0);
                end else begin
                    want_word = mean_q.pop_front();
                    if (got_word.mean !== want_word.mean) begin
                        report_mismatch("out_pixel", got_word.mean, want_word.mean);
                    end
                    if (got_word.row_end !== want_word.row_end) begin
                        report_mismatch("row_end", PIXEL_W'(got_word.row_end),
                                        PIXEL_W'(want_word.row_end));
                    end
                    if (got_word.frame_end !== want_word.frame_end) begin
                        report_mismatch("frame_end", PIXEL_W'(got_word.frame_end),
                                        PIXEL_W'(want_word.frame_end));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_mean('{i_pixel, i_frame_start});
                acc_cnt++;
            end
        end
    end

    // Waits until every pending word is taken and every expected mean is out,
    // then lets a word that closes no block finish inside the block.
    task automatic settle();
        while (!(pix_q.size() == 0 && acc_cnt == sent_cnt && mean_q.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One configuration word; the shadow copy follows at the accepting edge.
    task automatic write_reg(input t_cfg_idx idx, input int data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= DIM_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SCALE:  cfg_scale  = SCALE_W'(data);
            CFG_WIDTH:  cfg_width  = DIM_W'(data);
            CFG_HEIGHT: cfg_height = DIM_W'(data);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int s, input int w, input int h);
        settle();
        write_reg(CFG_SCALE, s);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // Queues random pixels; stray frame starts appear now and then when asked.
    task automatic push_pixels(input int count, input bit first_fs, input bit noisy);
        pix_word_t word;
        for (int k = 0; k < count; k++) begin
            word.pix = rand_pixel();
            word.fs  = (k == 0) ? first_fs : (noisy && $urandom_range(0, 99) == 0);
            pix_q.push_back(word);
        end
    endtask

    task automatic push_fixed(input logic [PIXEL_W-1:0] pix, input bit fs);
        pix_q.push_back('{pix, fs});
    endtask

    // Run length guard.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus.
    initial begin : stim
        int s, w, h, n, full, pick, rand_items, nframes;
        bit fs;

        for (int k = 0; k < MAX_WIDTH; k++) col_sum_mem[k] = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: every pixel is its own block.
        push_fixed(8'd0, 1'b1);
        push_fixed(8'd255, 1'b0);
        push_fixed(8'd1, 1'b0);
        push_fixed(8'd128, 1'b1);

        // Two by two blocks with a dropped right column, then a frame that
        // follows on without a frame start.
        set_geometry(2, 3, 2);
        push_fixed(8'd255, 1'b1);
        push_fixed(8'd255, 1'b0);
        push_fixed(8'd7, 1'b0);
        push_fixed(8'd255, 1'b0);
        push_fixed(8'd254, 1'b0);
        push_fixed(8'd9, 1'b0);
        push_fixed(8'd1, 1'b0);
        push_fixed(8'd2, 1'b0);
        push_fixed(8'd255, 1'b0);
        push_fixed(8'd0, 1'b0);
        push_fixed(8'd0, 1'b0);
        push_fixed(8'd0, 1'b0);

        // Zero scale, width and height all act as one.
        set_geometry(0, 0, 0);
        push_fixed(8'd77, 1'b1);
        push_fixed(8'd200, 1'b0);

        // A write to the unused index changes nothing; the scale register keeps
        // only its low bits.
        settle();
        write_reg(CFG_UNUSED, 13'h1FFF);
        push_fixed(8'd5, 1'b0);
        settle();
        write_reg(CFG_SCALE, 13'h1F82);

        // Width shrinks in the middle of a frame.
        set_geometry(2, 4, 4);
        push_pixels(4, 1'b1, 1'b0);
        settle();
        write_reg(CFG_WIDTH, 2);
        push_pixels(4, 1'b0, 1'b0);

        // Scale saturates to the largest block; one row closes a block column
        // but never a whole block.
        set_geometry(127, 64, 1);
        push_pixels(64, 1'b1, 1'b0);

        // Width saturates, so no row end shows in the first pixels.
        set_geometry(1, 8191, 1);
        push_pixels(40, 1'b1, 1'b0);

        // Height saturates, so no frame end shows in the first rows.
        idle_level = 2;
        set_geometry(1, 1, 8191);
        push_pixels(40, 1'b1, 1'b0);

        // Output held off for a long stretch while pixels keep coming.
        set_geometry(1, 8, 8);
        stall_go = 1'b1;
        push_pixels(64, 1'b1, 1'b0);

        // Random geometries: mostly whole frames, some cut short or left to wrap.
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                s = 0;
            end else if (pick < 12) begin
                s = $urandom_range(1, 4);
            end else begin
                s = $urandom_range(5, 9);
            end
            w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 16);
            h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(17, 48);
                h = $urandom_range(1, 4);
            end
            idle_level = $urandom_range(0, 2);
            set_geometry(s, w, h);
            full    = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            nframes = $urandom_range(1, 2);
            for (int f = 0; f < nframes; f++) begin
                n  = full;
                fs = 1'b1;
                case ($urandom_range(0, 9))
                    0:       n  = $urandom_range(1, full);
                    1:       fs = 1'b0;
                    default: ;
                endcase
                push_pixels(n, fs, 1'b1);
                rand_items += n;
            end
            if ($urandom_range(0, 3) == 0) settle();
        end

        // Closing stretch with no idling on either side.
        idle_level = 0;
        set_geometry(2, 10, 6);
        push_pixels(60, 1'b1, 1'b0);
        settle();

        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/bxds_pkg.sv
sv/bxds_ram.sv
sv/bxds_div.sv
sv/box_average_downscaler_core.sv
dv/tb_box_average_downscaler_core.sv
